### hdl/assert_macros.svh
// Assertion macros for the file that checks its own logic (complex_arith_unit).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off during reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also active while reset is asserted.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
package cau_pkg;

  localparam int FIELD_W = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // Control that travels with an item down the divider chain.
  typedef struct packed {
    op_t  op;
    logic neg_re;
    logic neg_im;
    logic dz;
    logic ovf_re;
    logic ovf_im;
  } cau_ctl_t;

endpackage

### hdl/cau_in_if.sv
// Operand channel: valid, ready and one operand item.
interface cau_in_if import cau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic signed [FIELD_W-1:0] a_re;
  logic signed [FIELD_W-1:0] a_im;
  logic signed [FIELD_W-1:0] b_re;
  logic signed [FIELD_W-1:0] b_im;

  modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, func, a_re, a_im, b_re, b_im, output ready);
endinterface

### hdl/cau_out_if.sv
// Result channel: valid, ready and one result item.
interface cau_out_if import cau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] res_re;
  logic signed [FIELD_W-1:0] res_im;
  logic [1:0]                status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink (input valid, res_re, res_im, status, output ready);
endinterface

### hdl/complex_arith_unit.sv
// Top level of the pipelined complex arithmetic unit.
// Usage:
//   req carries one operation item: func (add, subtract, multiply, divide)
//   and the operands a and b in signed fixed point. Only the low DATA_WIDTH
//   bits of each operand are used. rsp carries res_re, res_im (saturated,
//   sign-extended to 32 bits) and status (ok, divide by zero, overflow).
//   An item is taken on each edge where valid and ready are both high.
// Throughput: one item per cycle while rsp is not stalled. Stages: three
//   front stages (operand products, sums and magnitudes, divider
//   setup), one division cell per quotient bit, and the output register.
//   Every operation walks the same cell chain, so results keep their order.
// Reset: synchronous, active high; it empties every stage. Data registers are not reset.
// Stalls: each stage holds its item while the stage after it is full, so
//   req keeps accepting items until the chain backs up to the front; a
//   result waiting on rsp stops each full stage whose next stage is full.
module complex_arith_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  cau_in_if.sink   req,
  cau_out_if.source rsp
);
  `include "assert_macros.svh"

  localparam int W  = DATA_WIDTH;
  localparam int RW = 2*W + FRAC_BITS;
  localparam logic [2*W-1:0] LIM = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  logic           c_valid [W+1];
  logic           c_ready [W+1];
  cau_ctl_t       c_ctl   [W+1];
  logic [2*W-1:0] c_den   [W+1];
  logic [RW-1:0]  c_rem_re[W+1];
  logic [RW-1:0]  c_rem_im[W+1];
  logic [W-1:0]   c_q_re  [W+1];
  logic [W-1:0]   c_q_im  [W+1];

  cau_prep #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .func      (req.func),
    .a_re      (req.a_re[W-1:0]),
    .a_im      (req.a_im[W-1:0]),
    .b_re      (req.b_re[W-1:0]),
    .b_im      (req.b_im[W-1:0]),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .ctl       (c_ctl[0]),
    .den       (c_den[0]),
    .rem_re    (c_rem_re[0]),
    .rem_im    (c_rem_im[0])
  );

  assign c_q_re[0] = '0;
  assign c_q_im[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    cau_div_cell #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .K(W-1-i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .up_valid  (c_valid[i]),
      .up_ready  (c_ready[i]),
      .up_ctl    (c_ctl[i]),
      .up_den    (c_den[i]),
      .up_rem_re (c_rem_re[i]),
      .up_rem_im (c_rem_im[i]),
      .up_q_re   (c_q_re[i]),
      .up_q_im   (c_q_im[i]),
      .dn_valid  (c_valid[i+1]),
      .dn_ready  (c_ready[i+1]),
      .dn_ctl    (c_ctl[i+1]),
      .dn_den    (c_den[i+1]),
      .dn_rem_re (c_rem_re[i+1]),
      .dn_rem_im (c_rem_im[i+1]),
      .dn_q_re   (c_q_re[i+1]),
      .dn_q_im   (c_q_im[i+1])
    );
  end

  // Returns {saturated, W-bit two's complement value}.
  function automatic logic [W:0] fit(input logic neg, input logic [2*W-1:0] m,
                                     input logic sat_in);
    logic           sat;
    logic [2*W-1:0] v;
    logic [W-1:0]   r;
    sat = sat_in || (neg ? (m > LIM) : (m > LIM - 1'b1));
    v   = sat ? (neg ? LIM : LIM - 1'b1) : m;
    r   = neg ? (~v[W-1:0] + 1'b1) : v[W-1:0];
    return {sat, r};
  endfunction

  cau_ctl_t       fc;
  logic           is_div;
  logic [2*W-1:0] m_re, m_im;
  logic [W:0]     f_re, f_im;
  logic           go;

  always_comb begin
    fc     = c_ctl[W];
    is_div = (fc.op == OP_DIV);
    m_re   = is_div ? {{W{1'b0}}, c_q_re[W]} : c_rem_re[W][2*W-1:0];
    m_im   = is_div ? {{W{1'b0}}, c_q_im[W]} : c_rem_im[W][2*W-1:0];
    f_re   = fit(fc.neg_re, m_re, fc.ovf_re);
    f_im   = fit(fc.neg_im, m_im, fc.ovf_im);
  end

  assign go = !rsp.valid || rsp.ready;
  assign c_ready[W] = go;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (go) begin
      rsp.valid <= c_valid[W];
    end
    if (go && c_valid[W]) begin
      if (fc.dz) begin
        rsp.res_re <= '0;
        rsp.res_im <= '0;
        rsp.status <= ST_DZ;
      end else begin
        rsp.res_re <= FIELD_W'($signed(f_re[W-1:0]));
        rsp.res_im <= FIELD_W'($signed(f_im[W-1:0]));
        rsp.status <= (f_re[W] || f_im[W]) ? ST_OVF : ST_OK;
      end
    end
  end

  `CAU_ASSERT(a_dz_zero, rsp.valid && rsp.status == ST_DZ |-> rsp.res_re == '0 && rsp.res_im == '0, "divide by zero item with nonzero result")
  `CAU_ASSERT(a_status_code, rsp.valid |-> rsp.status == ST_OK || rsp.status == ST_DZ || rsp.status == ST_OVF, "undefined status code")
  `CAU_ASSERT(a_sign_ext, rsp.valid |-> (rsp.res_re[FIELD_W-1:W-1] == '0 || rsp.res_re[FIELD_W-1:W-1] == '1) && (rsp.res_im[FIELD_W-1:W-1] == '0 || rsp.res_im[FIELD_W-1:W-1] == '1), "result not sign-extended")
  `CAU_ASSERT(a_chain_move, c_valid[W] && go |=> rsp.valid, "finished item lost at output register")
endmodule

### hdl/cau_prep.sv
// Front end: products, sums with clamping, magnitudes and divider setup.
module cau_prep import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic signed [DATA_WIDTH-1:0] a_re,
  input  logic signed [DATA_WIDTH-1:0] a_im,
  input  logic signed [DATA_WIDTH-1:0] b_re,
  input  logic signed [DATA_WIDTH-1:0] b_im,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cau_ctl_t                     ctl,
  output logic [2*DATA_WIDTH-1:0]      den,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_re,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_im
);
  localparam int W  = DATA_WIDTH;
  localparam int SW = 2*W + 1;
  localparam int RW = 2*W + FRAC_BITS;
  localparam int XW = 3*W + FRAC_BITS;
  // Sums of products are clamped to the symmetric 64-bit range.
  localparam logic [SW-1:0] CMAX =
    (SW > 64) ? SW'(64'h7FFF_FFFF_FFFF_FFFF) : {SW{1'b1}};

  logic rdy1, rdy2, rdy3;
  logic v1, v2;
  op_t  op1, op2;
  logic signed [2*W-1:0] prr, pii, pri, pir;
  logic [2*W-1:0] sqr, sqi;
  logic signed [W:0] sre, sim;

  logic signed [SW-1:0] sum_re, sum_im;
  logic [SW-1:0] abs_re, abs_im, clp_re, clp_im;
  logic neg_re2, neg_im2;
  logic [2*W-1:0] m_re2, m_im2, den2;
  logic dz3, ovf_re3, ovf_im3;

  assign rdy3 = !out_valid || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      op1 <= op_t'(func);
      prr <= a_re * b_re;
      pii <= a_im * b_im;
      pri <= a_re * b_im;
      pir <= a_im * b_re;
      sqr <= $unsigned((2*W)'(b_re) * (2*W)'(b_re));
      sqi <= $unsigned((2*W)'(b_im) * (2*W)'(b_im));
      if (op_t'(func) == OP_SUB) begin
        sre <= a_re - b_re;
        sim <= a_im - b_im;
      end else begin
        sre <= a_re + b_re;
        sim <= a_im + b_im;
      end
    end
  end

  always_comb begin
    case (op1)
      OP_MUL: begin
        sum_re = SW'(prr) - SW'(pii);
        sum_im = SW'(pri) + SW'(pir);
      end
      OP_DIV: begin
        sum_re = SW'(prr) + SW'(pii);
        sum_im = SW'(pir) - SW'(pri);
      end
      default: begin
        sum_re = SW'(sre);
        sum_im = SW'(sim);
      end
    endcase
    abs_re = sum_re[SW-1] ? SW'(-sum_re) : SW'(sum_re);
    abs_im = sum_im[SW-1] ? SW'(-sum_im) : SW'(sum_im);
    clp_re = (abs_re > CMAX) ? CMAX : abs_re;
    clp_im = (abs_im > CMAX) ? CMAX : abs_im;
    if (op1 == OP_MUL) begin
      clp_re = clp_re >> FRAC_BITS;
      clp_im = clp_im >> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      op2     <= op1;
      neg_re2 <= sum_re[SW-1];
      neg_im2 <= sum_im[SW-1];
      m_re2   <= clp_re[2*W-1:0];
      m_im2   <= clp_im[2*W-1:0];
      den2    <= sqr + sqi;
    end
  end

  // A quotient of more than W integer-plus-fraction bits saturates in any case.
  always_comb begin
    dz3     = (den2 == '0);
    ovf_re3 = (XW'(m_re2) << FRAC_BITS) >= (XW'(den2) << W);
    ovf_im3 = (XW'(m_im2) << FRAC_BITS) >= (XW'(den2) << W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= v2;
    end
    if (rdy3 && v2) begin
      ctl.op     <= op2;
      ctl.neg_re <= neg_re2;
      ctl.neg_im <= neg_im2;
      ctl.dz     <= (op2 == OP_DIV) && dz3;
      ctl.ovf_re <= (op2 == OP_DIV) && ovf_re3;
      ctl.ovf_im <= (op2 == OP_DIV) && ovf_im3;
      den        <= den2;
      if (op2 == OP_DIV) begin
        rem_re <= RW'(m_re2) << FRAC_BITS;
        rem_im <= RW'(m_im2) << FRAC_BITS;
      end else begin
        rem_re <= RW'(m_re2);
        rem_im <= RW'(m_im2);
      end
    end
  end
endmodule

### hdl/cau_div_cell.sv
// One restoring-division cell: decides quotient bit K of both components.
module cau_div_cell import cau_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int K          = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  cau_ctl_t                          up_ctl,
  input  logic [2*DATA_WIDTH-1:0]           up_den,
  input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] up_rem_re,
  input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] up_rem_im,
  input  logic [DATA_WIDTH-1:0]             up_q_re,
  input  logic [DATA_WIDTH-1:0]             up_q_im,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output cau_ctl_t                          dn_ctl,
  output logic [2*DATA_WIDTH-1:0]           dn_den,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] dn_rem_re,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] dn_rem_im,
  output logic [DATA_WIDTH-1:0]             dn_q_re,
  output logic [DATA_WIDTH-1:0]             dn_q_im
);
  localparam int W  = DATA_WIDTH;
  localparam int RW = 2*W + FRAC_BITS;
  localparam int XW = 3*W + FRAC_BITS;

  logic [XW-1:0] dsh;
  logic          live, take_re, take_im;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    dsh     = XW'(up_den) << K;
    live    = (up_ctl.op == OP_DIV) && !up_ctl.dz;
    take_re = live && !up_ctl.ovf_re && (XW'(up_rem_re) >= dsh);
    take_im = live && !up_ctl.ovf_im && (XW'(up_rem_im) >= dsh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_ctl    <= up_ctl;
      dn_den    <= up_den;
      dn_rem_re <= take_re ? (up_rem_re - dsh[RW-1:0]) : up_rem_re;
      dn_rem_im <= take_im ? (up_rem_im - dsh[RW-1:0]) : up_rem_im;
      dn_q_re   <= take_re ? (up_q_re | (W'(1) << K)) : up_q_re;
      dn_q_im   <= take_im ? (up_q_im | (W'(1) << K)) : up_q_im;
    end
  end
endmodule

### tb/complex_arith_unit_tb.sv
// Self-checking testbench of the complex arithmetic unit: directed table, then random items.
module complex_arith_unit_tb;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = DW + 4;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic [1:0]  st;
  } cplx_res_t;

  typedef struct {
    op_t         op;
    logic [31:0] ar, ai, br, bi;
    bit          typed;
    cplx_res_t   res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   cycles = 0;

  cau_in_if  req();
  cau_out_if rsp();

  complex_arith_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cplx_res_t pending_results[$];

  // Saturate a sign and magnitude to the data range.
  function automatic logic [31:0] sat_fit(input logic neg, input logic [95:0] mag,
                                          inout logic ovf);
    logic [95:0] lim;
    logic [95:0] m;
    lim = 96'd1 << (DW - 1);
    m = mag;
    if (neg) begin
      if (m > lim) begin
        m = lim;
        ovf = 1'b1;
      end
      return 32'(-m);
    end
    if (m > lim - 1) begin
      m = lim - 1;
      ovf = 1'b1;
    end
    return 32'(m);
  endfunction

  // Sums of products are held to +/- (2^63 - 1), as the divider sees them.
  function automatic logic signed [67:0] clamp63(input logic signed [67:0] v);
    logic signed [67:0] mx;
    mx = (68'sd1 <<< 63) - 68'sd1;
    if (v > mx) return mx;
    if (v < -mx) return -mx;
    return v;
  endfunction

  function automatic logic [95:0] mag_of(input logic signed [67:0] v);
    return (v < 0) ? 96'(-v) : 96'(v);
  endfunction

  function automatic cplx_res_t complex_result(input op_t op, input logic [31:0] ar_b,
                                               input logic [31:0] ai_b,
                                               input logic [31:0] br_b,
                                               input logic [31:0] bi_b);
    logic signed [67:0] ar, ai, br, bi, vr, vi;
    logic [95:0] den;
    logic ovf;
    cplx_res_t r;
    ar = 68'(signed'(ar_b[DW-1:0]));
    ai = 68'(signed'(ai_b[DW-1:0]));
    br = 68'(signed'(br_b[DW-1:0]));
    bi = 68'(signed'(bi_b[DW-1:0]));
    ovf = 1'b0;
    r.re = '0;
    r.im = '0;
    r.st = ST_OK;
    case (op)
      OP_ADD: begin
        vr = ar + br;
        vi = ai + bi;
        r.re = sat_fit(vr < 0, mag_of(vr), ovf);
        r.im = sat_fit(vi < 0, mag_of(vi), ovf);
      end
      OP_SUB: begin
        vr = ar - br;
        vi = ai - bi;
        r.re = sat_fit(vr < 0, mag_of(vr), ovf);
        r.im = sat_fit(vi < 0, mag_of(vi), ovf);
      end
      OP_MUL: begin
        vr = clamp63(ar * br - ai * bi);
        vi = clamp63(ar * bi + ai * br);
        r.re = sat_fit(vr < 0, mag_of(vr) >> FB, ovf);
        r.im = sat_fit(vi < 0, mag_of(vi) >> FB, ovf);
      end
      default: begin
        den = 96'(br * br + bi * bi);
        if (den == 0) begin
          r.st = ST_DZ;
        end else begin
          vr = clamp63(ar * br + ai * bi);
          vi = clamp63(ai * br - ar * bi);
          r.re = sat_fit(vr < 0, (mag_of(vr) << FB) / den, ovf);
          r.im = sat_fit(vi < 0, (mag_of(vi) << FB) / den, ovf);
        end
      end
    endcase
    if (ovf) r.st = ST_OVF;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Typed expectations override the predictor for rows that carry one.
  bit        typed_q[$];
  cplx_res_t typed_res_q[$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
    if (!rst && req.valid && req.ready) begin
      cplx_res_t p;
      p = complex_result(op_t'(req.func), req.a_re, req.a_im, req.b_re, req.b_im);
      if (typed_q.size() != 0 && typed_q.pop_front()) p = typed_res_q.pop_front();
      pending_results.push_back(p);
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", rsp.res_re, '0);
      end else begin
        cplx_res_t e;
        e = pending_results.pop_front();
        if (rsp.res_re !== e.re) report_mismatch("res_re", rsp.res_re, e.re);
        if (rsp.res_im !== e.im) report_mismatch("res_im", rsp.res_im, e.im);
        if (rsp.status !== e.st) report_mismatch("status", 32'(rsp.status), 32'(e.st));
      end
    end
  end

  // Receiver back-pressure: switches between always ready, periodic and random stalls.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 120);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= (cycles % 5) != 0;
        2: rsp.ready <= $urandom_range(0, 3) != 0;
        default: rsp.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  int burst_left = 0;

  task automatic send_item(input op_t op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req.valid <= 1'b1;
    req.func  <= op;
    req.a_re  <= ar;
    req.a_im  <= ai;
    req.b_re  <= br;
    req.b_im  <= bi;
    do @(posedge clk); while (!req.ready);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return 32'(signed'(16'($urandom))) <<< $urandom_range(0, 16);
      4: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MAXN = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  vec_row_t dir_rows[] = '{
    '{OP_ADD, ONE, ONE, ONE, ONE, 1, '{32'h0002_0000, 32'h0002_0000, ST_OK}},
    '{OP_ADD, MAXP, MAXN, ONE, 32'hffff_0000, 1, '{MAXP, MAXN, ST_OVF}},
    '{OP_ADD, MAXP, MAXN, MAXN, MAXP, 1, '{32'hffff_ffff, 32'hffff_ffff, ST_OK}},
    '{OP_SUB, MAXN, MAXP, ONE, 32'hffff_0000, 1, '{MAXN, MAXP, ST_OVF}},
    '{OP_SUB, 32'h0, 32'h0, MAXN, MAXN, 1, '{MAXP, MAXP, ST_OVF}},
    '{OP_SUB, ONE, ONE, ONE, ONE, 1, '{32'h0, 32'h0, ST_OK}},
    '{OP_MUL, ONE, 32'h0, ONE, 32'h0, 1, '{ONE, 32'h0, ST_OK}},
    '{OP_MUL, MAXP, MAXP, MAXP, MAXP, 1, '{32'h0, MAXP, ST_OVF}},
    '{OP_MUL, MAXN, MAXN, MAXN, MAXN, 1, '{32'h0, MAXP, ST_OVF}},
    '{OP_MUL, MAXN, MAXP, MAXP, MAXN, 0, '{0, 0, 0}},
    '{OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0, 0, '{0, 0, 0}},
    '{OP_MUL, 32'h0003_8000, 32'hfffe_4000, 32'h0001_2000, 32'h0002_0000, 0, '{0, 0, 0}},
    '{OP_DIV, ONE, ONE, 32'h0, 32'h0, 1, '{32'h0, 32'h0, ST_DZ}},
    '{OP_DIV, MAXP, MAXN, 32'h0, 32'h0, 1, '{32'h0, 32'h0, ST_DZ}},
    '{OP_DIV, ONE, 32'h0, ONE, 32'h0, 1, '{ONE, 32'h0, ST_OK}},
    '{OP_DIV, MAXN, MAXN, MAXN, MAXN, 0, '{0, 0, 0}},
    '{OP_DIV, MAXP, MAXP, 32'h0000_0001, 32'h0, 1, '{MAXP, MAXP, ST_OVF}},
    '{OP_DIV, MAXN, MAXP, 32'h0, 32'h0000_0001, 0, '{0, 0, 0}},
    '{OP_DIV, 32'h0003_0000, 32'hfffc_0000, 32'h0001_8000, 32'h0000_4000, 0, '{0, 0, 0}},
    '{OP_DIV, 32'h0000_0001, 32'h0, MAXP, MAXN, 0, '{0, 0, 0}}
  };

  initial begin
    int wait_cycles;
    op_t op;
    logic [31:0] br, bi;
    req.valid = 1'b0;
    req.func  = OP_ADD;
    req.a_re  = '0;
    req.a_im  = '0;
    req.b_re  = '0;
    req.b_im  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      typed_q.push_back(dir_rows[i].typed);
      if (dir_rows[i].typed) typed_res_q.push_back(dir_rows[i].res);
      send_item(dir_rows[i].op, dir_rows[i].ar, dir_rows[i].ai, dir_rows[i].br,
                dir_rows[i].bi);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      op = op_t'($urandom_range(0, 3));
      br = rand_operand();
      bi = rand_operand();
      // Give the divider a zero divisor now and then.
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(op, rand_operand(), rand_operand(), br, bi);
    end
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    wait_cycles = LATENCY + 20;
    repeat (wait_cycles) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
